// File: design/deq_pkg.sv
// Package: operation and status codes and the cell control type for the deque.
`default_nettype none

package deq_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic write_rear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/deq_if.sv
// Interfaces: request and response channels of the deque.
`default_nettype none

interface deq_req_if;
    logic                               valid;
    logic                               ready;
    logic [deq_pkg::OP_W-1:0]           op;
    logic signed [deq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface deq_rsp_if #(
    parameter int OCC_W = 5
);
    logic                               valid;
    logic                               ready;
    logic [deq_pkg::STAT_W-1:0]         status;
    logic signed [deq_pkg::VALUE_W-1:0] front_value;
    logic signed [deq_pkg::VALUE_W-1:0] rear_value;
    logic                               is_empty;
    logic [OCC_W-1:0]                   occupancy;

    modport source (output valid, output status, output front_value, output rear_value,
                    output is_empty, output occupancy, input ready);
    modport sink   (input valid, input status, input front_value, input rear_value,
                    input is_empty, input occupancy, output ready);
endinterface

`default_nettype wire

// File: design/deq_cell.sv
// Storage cell: one element slot that shifts toward either neighbor.
`default_nettype none

module deq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire                                clk,
    input  wire deq_pkg::cell_ctrl_t           ctrl,
    input  wire logic [CNT_W-1:0]              count,
    input  wire logic signed [deq_pkg::VALUE_W-1:0] value,
    input  wire logic signed [deq_pkg::VALUE_W-1:0] left_data,
    input  wire logic signed [deq_pkg::VALUE_W-1:0] right_data,
    output logic signed [deq_pkg::VALUE_W-1:0] data,
    output logic signed [deq_pkg::VALUE_W-1:0] rear_tap
);

    localparam logic [CNT_W-1:0] MY_POS   = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(INDEX + 1);

    logic signed [deq_pkg::VALUE_W-1:0] data_reg;
    logic signed [deq_pkg::VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.shift_right)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_left)
        begin
            data_next = right_data;
        end
        else if (ctrl.write_rear && (count == MY_POS))
        begin
            data_next = value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign rear_tap = (count == LAST_CNT) ? data_reg : '0;

endmodule

`default_nettype wire

// File: design/double_ended_queue.sv
// Top level: bounded deque built from a row of shifting storage cells.
// Holds up to CAPACITY signed 32-bit elements, front in cell 0 and the rear in cell
// occupancy-1. Each request transaction (push front, push rear, pop front, pop rear)
// yields one response carrying status, front and rear values, empty flag and occupancy.
// The accept edge shifts or writes the cell row and sets a busy flag; while it is set the
// response register is loaded from the cells, and no new request is accepted. Otherwise a
// new request is accepted in the cycle the previous response is taken, so each transaction
// finishes before the next begins. Pushes into a full deque report overflow and pops
// from an empty one report underflow, leaving the contents unchanged.
`default_nettype none

module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam int               CNT_W    = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               busy_reg;
    logic [deq_pkg::STAT_W-1:0]         stat_reg;
    logic [deq_pkg::STAT_W-1:0]         stat_next;
    logic                               rsp_valid_reg;
    logic [deq_pkg::STAT_W-1:0]         rsp_status_reg;
    logic signed [deq_pkg::VALUE_W-1:0] rsp_front_reg;
    logic signed [deq_pkg::VALUE_W-1:0] rsp_rear_reg;
    logic                               rsp_empty_reg;
    logic [CNT_W-1:0]                   rsp_occ_reg;

    logic                               accept;
    logic                               is_full;
    logic                               is_void;
    deq_pkg::cell_ctrl_t                ctrl;
    logic signed [deq_pkg::VALUE_W-1:0] cell_data [CAPACITY];
    logic signed [deq_pkg::VALUE_W-1:0] cell_tap  [CAPACITY];
    logic signed [deq_pkg::VALUE_W-1:0] rear_sel;

    assign req.ready = !busy_reg && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign is_full   = (count_reg == FULL_CNT);
    assign is_void   = (count_reg == '0);

    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        stat_next  = deq_pkg::STATUS_OK;
        unique case (req.op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    stat_next = deq_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    ctrl.shift_right = accept;
                    count_next       = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::OP_PUSH_REAR:
            begin
                if (is_full)
                begin
                    stat_next = deq_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    ctrl.write_rear = accept;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (is_void)
                begin
                    stat_next = deq_pkg::STATUS_UNDERFLOW;
                end
                else
                begin
                    ctrl.shift_left = accept;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            deq_pkg::OP_POP_REAR:
            begin
                if (is_void)
                begin
                    stat_next = deq_pkg::STATUS_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                stat_next = deq_pkg::STATUS_OK;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [deq_pkg::VALUE_W-1:0] left_d;
        logic signed [deq_pkg::VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = req.value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        deq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .value      (req.value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rear_tap   (cell_tap[i])
        );
    end

    always_comb
    begin
        rear_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rear_sel = rear_sel | cell_tap[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            busy_reg       <= 1'b0;
            stat_reg       <= deq_pkg::STATUS_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= deq_pkg::STATUS_OK;
            rsp_front_reg  <= '0;
            rsp_rear_reg   <= '0;
            rsp_empty_reg  <= 1'b1;
            rsp_occ_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                stat_reg  <= stat_next;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                busy_reg <= 1'b0;
            end

            if (busy_reg)
            begin
                rsp_valid_reg  <= 1'b1;
                rsp_status_reg <= stat_reg;
                rsp_front_reg  <= is_void ? '0 : cell_data[0];
                rsp_rear_reg   <= rear_sel;
                rsp_empty_reg  <= is_void;
                rsp_occ_reg    <= count_reg;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.front_value = rsp_front_reg;
    assign rsp.rear_value  = rsp_rear_reg;
    assign rsp.is_empty    = rsp_empty_reg;
    assign rsp.occupancy   = rsp_occ_reg;

endmodule

`default_nettype wire

// File: design/deq_checker.sv
// Checker: port-level properties of the deque responses, bound to the top level.
`default_nettype none

module deq_checker #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                rsp_valid,
    input wire                                rsp_ready,
    input wire [deq_pkg::STAT_W-1:0]          rsp_status,
    input wire signed [deq_pkg::VALUE_W-1:0]  rsp_front,
    input wire signed [deq_pkg::VALUE_W-1:0]  rsp_rear,
    input wire                                rsp_empty,
    input wire [CNT_W-1:0]                    rsp_occ
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_empty == (rsp_occ == '0)))
        else $error("empty flag disagrees with occupancy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_empty) |-> (rsp_front == '0 && rsp_rear == '0))
        else $error("empty deque reports nonzero values");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status == deq_pkg::STATUS_OVERFLOW) |-> (rsp_occ == FULL_CNT))
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status == deq_pkg::STATUS_UNDERFLOW) |-> rsp_empty)
        else $error("underflow reported while not empty");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_occ) && $stable(rsp_rear)))
        else $error("stalled response changed");

endmodule

bind double_ended_queue deq_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_deq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_front  (rsp.front_value),
    .rsp_rear   (rsp.rear_value),
    .rsp_empty  (rsp.is_empty),
    .rsp_occ    (rsp.occupancy)
);

`default_nettype wire
